/* rtl/arpc_pkg.sv */
// Shared types, sizes and codes for the ARP cache table.
// Used by arpc_scan and arp_cache_table; depends on nothing.
package arpc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int SLOT_W      = 4;
    localparam int ENTRY_W     = IP_W + MAC_W;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_ADD    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OUT_UPDATED   = 2'd0,
        OUT_FILLED    = 2'd1,
        OUT_OVERWROTE = 2'd2
    } t_outcome;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [MAC_W-1:0]  found_mac;
        logic [SLOT_W-1:0] slot;
        t_outcome          outcome;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_mem_req;

    // Entry index as reported on the slot port: low bits, zero-extended if narrow.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/arpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/arpc_scan.sv */
// Request sequencer: walks the entry RAM one entry per cycle, tracks the valid
// bits, decides hit, update, fill or overwrite, and issues the write-back. Uses arpc_pkg.
module arpc_scan import arpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_operation,
    input  logic [IP_W-1:0]    i_ip_address,
    input  logic [MAC_W-1:0]   i_mac_address,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output logic               o_busy,
    output t_mem_req           o_mem,
    output t_result            o_result
);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic                 r_free_found, n_free_found;
    t_op                  r_op;
    logic [IP_W-1:0]      r_ip;
    logic [MAC_W-1:0]     r_mac;
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [IP_W-1:0]  ent_ip;
    logic [MAC_W-1:0] ent_mac;
    logic             is_match;
    logic             is_last;
    logic             decide;
    logic             free_now;
    logic [IDX_W-1:0] free_idx_now;
    logic             valid_set;
    logic [IDX_W-1:0] valid_idx;

    assign ent_ip       = i_rd_data[ENTRY_W-1:MAC_W];
    assign ent_mac      = i_rd_data[MAC_W-1:0];
    assign is_match     = r_valid[r_idx] && (ent_ip == r_ip);
    assign is_last      = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign decide       = (r_state == ST_SCAN) && (is_match || is_last);
    assign free_now     = r_free_found || !r_valid[r_idx];
    assign free_idx_now = r_free_found ? r_free_idx : r_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (decide) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Walk counter and first free entry seen so far
    always_comb begin
        n_idx        = r_idx;
        n_free_idx   = r_free_idx;
        n_free_found = r_free_found;
        if (r_state == ST_IDLE) begin
            n_idx        = '0;
            n_free_found = 1'b0;
        end else if (!decide) begin
            n_idx = r_idx + IDX_W'(1);
            if (!r_valid[r_idx] && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_idx;
            end
        end
    end

    // Outputs: RAM access, valid update, result
    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_mem.rd_addr = (r_state == ST_IDLE) ? '0 : r_idx + IDX_W'(1);
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_idx;
        o_mem.wr_data = {r_ip, r_mac};
        valid_set     = 1'b0;
        valid_idx     = free_idx_now;
        o_result      = '{done: 1'b0, hit: 1'b0, found_mac: '0, slot: '0,
                          outcome: OUT_UPDATED};
        if (decide) begin
            o_result.done = 1'b1;
            o_result.hit  = is_match;
            if (r_op == OP_LOOKUP) begin
                if (is_match) begin
                    o_result.found_mac = ent_mac;
                    o_result.slot      = to_slot(r_idx);
                end
            end else if (is_match) begin
                o_mem.wr_en      = 1'b1;
                o_result.slot    = to_slot(r_idx);
                o_result.outcome = OUT_UPDATED;
            end else if (free_now) begin
                o_mem.wr_en      = 1'b1;
                o_mem.wr_addr    = free_idx_now;
                valid_set        = 1'b1;
                o_result.slot    = to_slot(free_idx_now);
                o_result.outcome = OUT_FILLED;
            end else begin
                o_mem.wr_en      = 1'b1;
                o_mem.wr_addr    = '0;
                o_result.outcome = OUT_OVERWROTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_free_idx   <= '0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_idx   <= n_free_idx;
            r_free_found <= n_free_found;
            if (valid_set) begin
                r_valid[valid_idx] <= 1'b1;
            end
        end
    end

    // Hold the request for the whole walk
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op  <= t_op'(i_operation);
            r_ip  <= i_ip_address;
            r_mac <= i_mac_address;
        end
    end

endmodule

/* rtl/arp_cache_table.sv */
// Top level of the ARP cache table: entry RAM, request sequencer, result register.
// Depends on arpc_pkg, arpc_ram and arpc_scan.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  request   | start, busy (in: !busy)   | i_operation, i_ip_address, i_mac_address
//  result    | o_done (one-cycle strobe) | o_hit, o_found_mac, o_slot, o_add_outcome
//
// A request is taken when start is high and busy is low; the entry RAM is then
// read one entry per cycle from entry 0 until the first valid match or the last entry.
// Busy stays high for the whole walk, as the single RAM read port reads the entries in
// turn. The result strobe comes in the cycle after the last walk cycle, with busy already
// low, so the next request can be taken then; no new request is taken during a walk.
// Reset (synchronous, active low) marks all entries invalid at once; results cannot be stalled.
module arp_cache_table import arpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [IP_W-1:0]   i_ip_address,
    input  logic [MAC_W-1:0]  i_mac_address,
    output logic              o_done,
    output logic              o_hit,
    output logic [MAC_W-1:0]  o_found_mac,
    output logic [SLOT_W-1:0] o_slot,
    output logic [1:0]        o_add_outcome
);

    logic               accept;
    logic [ENTRY_W-1:0] rd_data;
    t_mem_req           mem_req;
    t_result            result;

    logic              r_done;
    logic              r_hit;
    logic [MAC_W-1:0]  r_found_mac;
    logic [SLOT_W-1:0] r_slot;
    t_outcome          r_outcome;

    assign accept = start && !busy;

    arpc_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    arpc_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_ip_address  (i_ip_address),
        .i_mac_address (i_mac_address),
        .i_rd_data     (rd_data),
        .o_busy        (busy),
        .o_mem         (mem_req),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= result.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.done) begin
            r_hit       <= result.hit;
            r_found_mac <= result.found_mac;
            r_slot      <= result.slot;
            r_outcome   <= result.outcome;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_found_mac   = r_found_mac;
    assign o_slot        = r_slot;
    assign o_add_outcome = r_outcome;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a request is in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not start a table walk");

    a_miss_no_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_found_mac == '0))
        else $error("MAC reported without a hit");

    a_hit_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_add_outcome == OUT_UPDATED))
        else $error("hit reported with a fill or overwrite outcome");

endmodule
